>>> rtl/aes128_key_expansion_top_defines.svh
// Assertion macros for the AES-128 key expansion block
`ifndef AES128_KEY_EXPANSION_TOP_DEFINES_SVH
`define AES128_KEY_EXPANSION_TOP_DEFINES_SVH
`ifndef SYNTH
`define AKE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AKE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKE_ASSERT(label, clk, rst_n, prop, msg)
`define AKE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/ake_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_pkg
// Types, constants and S-box table for AES-128 key expansion.
// ----------------------------------------------------------------------------
package ake_pkg;

    localparam int unsigned WORD_COUNT = 44;
    localparam logic [7:0]  RCON_INIT  = 8'h01;
    localparam logic [7:0]  GF_POLY    = 8'h1B;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } ake_in_t;

    typedef struct packed {
        logic [5:0]  word_index;
        logic [31:0] round_key_word;
        logic        last_word;
    } ake_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ake_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } ake_ctrl_t;

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        gf_double = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] lut [256];
        lut = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = lut[x];
    endfunction

endpackage

>>> rtl/ake_word_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_word_unit
// Shared word datapath: four-word window, round constant, next-word logic.
// ----------------------------------------------------------------------------
module ake_word_unit
    import ake_pkg::*;
(
    input  logic        aclk,
    input  ake_ctrl_t   ctrl,
    input  ake_in_t     key,
    input  logic [5:0]  index,
    output logic [31:0] word
);

    logic [31:0] win_reg [4];
    logic [31:0] win_next [4];
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] rot, sub, temp, new_word;

    assign rot = {win_reg[3][23:0], win_reg[3][31:24]};
    assign sub = {sbox(rot[31:24]), sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};
    assign temp = (index[1:0] == 2'd0) ? (sub ^ {rcon_reg, 24'h0}) : win_reg[3];
    assign new_word = win_reg[0] ^ temp;

    // words 0..3 come straight from the window
    assign word = (index < 6'd4) ? win_reg[index[1:0]] : new_word;

    always_comb begin
        win_next  = win_reg;
        rcon_next = rcon_reg;
        if (ctrl.load) begin
            win_next[0] = key.key_hi[63:32];
            win_next[1] = key.key_hi[31:0];
            win_next[2] = key.key_lo[63:32];
            win_next[3] = key.key_lo[31:0];
            rcon_next   = RCON_INIT;
        end else if (ctrl.advance && index >= 6'd4) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = new_word;
            if (index[1:0] == 2'd0) begin
                rcon_next = gf_double(rcon_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        rcon_reg <= rcon_next;
    end

endmodule

>>> rtl/ake_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_sequencer
// Word counter and handshake control for one key schedule.
// ----------------------------------------------------------------------------
`include "aes128_key_expansion_top_defines.svh"
module ake_sequencer
    import ake_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ake_ctrl_t  ctrl,
    output logic [5:0] index,
    output logic       last
);

    localparam logic [5:0] LAST_IDX = 6'(WORD_COUNT - 1);

    ake_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                state_next = ST_RUN;
                cnt_next   = 6'd0;
            end
            ST_RUN: if (m_ready) begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_RUN);
        ctrl.load    = s_valid && s_ready;
        ctrl.advance = m_valid && m_ready;
    end

    assign index = cnt_reg;
    assign last  = (cnt_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `AKE_ASSERT(a_idx_range, aclk, aresetn, m_valid |-> cnt_reg <= LAST_IDX, "index out of range")
    `AKE_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "ready while busy")
    `AKE_ASSERT(a_step, aclk, aresetn, (m_valid && m_ready && !last) |=> cnt_reg == $past(cnt_reg) + 6'd1, "counter skipped")
    `AKE_ASSERT(a_start, aclk, aresetn, (s_valid && s_ready) |=> (m_valid && cnt_reg == 6'd0), "bad start")

endmodule

>>> rtl/aes128_key_expansion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_key_expansion_top
// AES-128 key schedule generator, one word per cycle while m_ready is high.
// ----------------------------------------------------------------------------
// Input channel s_*: one 128-bit key per transfer (key_hi holds bytes 0..7).
// Output channel m_*: 44 transfers per key, words 0..43 in order, each with
// its index; last_word marks word 43.
// The first word is offered the cycle after the key transfer; every word
// comes from the single shared word unit.
// s_ready is high only while no schedule is in progress.
// A stall on m_ready holds the current word and index steady.
// Reset (aresetn low, synchronous) returns to idle and drops any partial
// schedule; no state carries from one key to the next.
// ----------------------------------------------------------------------------
module aes128_key_expansion_top
    import ake_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ake_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ake_out_t m_data
);

    ake_ctrl_t   ctrl;
    logic [5:0]  index;
    logic        last;
    logic [31:0] word;

    ake_sequencer u_seq (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .ctrl(ctrl), .index(index), .last(last)
    );

    ake_word_unit u_word (
        .aclk(aclk), .ctrl(ctrl), .key(s_data), .index(index), .word(word)
    );

    assign m_data.word_index     = index;
    assign m_data.round_key_word = word;
    assign m_data.last_word      = last;

endmodule
